@@ rtl/sfr_pkg.sv @@
// Shared constants, state encoding and control/status bundles for the
// serial frame receiver. No dependencies; imported by every rtl module.
`default_nettype none

package sfr_pkg;

    localparam int MAX_LEN     = 31;
    localparam int STORE_DEPTH = MAX_LEN + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int BYTE_W      = 8;
    localparam int REG_IDX_W   = 1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd85;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd204;

    localparam logic [REG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ST_HUNT_FIRST,
        ST_HUNT_SECOND,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_DRAIN
    } sfr_state_t;

    typedef struct packed {
        logic init_xor;
        logic add_hdr2;
        logic start_len;
        logic store_payload;
        logic start_drain;
        logic emit;
    } sfr_cmd_t;

    typedef struct packed {
        logic hdr1_match;
        logic hdr2_match;
        logic len_ok;
        logic left_zero;
        logic sum_match;
        logic out_load_ok;
        logic drain_last;
    } sfr_stat_t;

endpackage : sfr_pkg

`default_nettype wire

@@ rtl/sfr_ctrl.sv @@
// Frame hunting and output burst state machine of the serial frame receiver.
// Depends on sfr_pkg; drives the datapath through sfr_cmd_t.
`default_nettype none

module sfr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tuser,
    output logic                   s_tready,
    input  wire sfr_pkg::sfr_stat_t stat,
    output sfr_pkg::sfr_cmd_t      cmd
);
    import sfr_pkg::*;

    sfr_state_t state_reg;
    sfr_state_t state_next;
    logic       take;

    // Error bytes are transferred but otherwise ignored.
    assign take = s_tvalid && (state_reg != ST_DRAIN) && !s_tuser;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT_FIRST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT_FIRST:
            begin
                if (take && stat.hdr1_match)
                    state_next = ST_HUNT_SECOND;
            end
            ST_HUNT_SECOND:
            begin
                if (take)
                    state_next = stat.hdr2_match ? ST_LENGTH : ST_HUNT_FIRST;
            end
            ST_LENGTH:
            begin
                if (take)
                    state_next = stat.len_ok ? ST_PAYLOAD : ST_HUNT_FIRST;
            end
            ST_PAYLOAD:
            begin
                if (take && stat.left_zero)
                    state_next = stat.sum_match ? ST_DRAIN : ST_HUNT_FIRST;
            end
            ST_DRAIN:
            begin
                if (stat.out_load_ok && stat.drain_last)
                    state_next = ST_HUNT_FIRST;
            end
            default:
            begin
                state_next = ST_HUNT_FIRST;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b1;
        unique case (state_reg)
            ST_HUNT_FIRST:
            begin
                cmd.init_xor = take && stat.hdr1_match;
            end
            ST_HUNT_SECOND:
            begin
                cmd.add_hdr2 = take && stat.hdr2_match;
            end
            ST_LENGTH:
            begin
                cmd.start_len = take && stat.len_ok;
            end
            ST_PAYLOAD:
            begin
                cmd.store_payload = take && !stat.left_zero;
                cmd.start_drain   = take && stat.left_zero && stat.sum_match;
            end
            ST_DRAIN:
            begin
                s_tready = 1'b0;
                cmd.emit = stat.out_load_ok;
            end
            default:
            begin
                s_tready = 1'b1;
            end
        endcase
    end

endmodule : sfr_ctrl

`default_nettype wire

@@ rtl/sfr_dp.sv @@
// Datapath of the serial frame receiver: header registers, checksum,
// counters, frame memory and output register. Depends on sfr_pkg.
`default_nettype none

module sfr_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sfr_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::BYTE_W-1:0]     cfg_data,
    input  wire logic [sfr_pkg::BYTE_W-1:0]     rx_byte,
    input  wire sfr_pkg::sfr_cmd_t              cmd,
    output sfr_pkg::sfr_stat_t                  stat,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]          m_tdata,
    output logic                                m_tlast
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] hdr_first_reg;
    logic [BYTE_W-1:0] hdr_second_reg;
    logic [BYTE_W-1:0] xor_reg;
    logic [CNT_W-1:0]  windex_reg;
    logic [LEN_W-1:0]  left_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              fetch_valid_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              store_en;
    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];

    assign store_en = cmd.start_len || cmd.store_payload;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= HEADER_FIRST_RST;
            hdr_second_reg <= HEADER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  hdr_first_reg  <= cfg_data;
                REG_HEADER_SECOND: hdr_second_reg <= cfg_data;
                default:           hdr_first_reg  <= hdr_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg         <= '0;
            windex_reg      <= '0;
            left_reg        <= '0;
            len_reg         <= '0;
            rd_addr_reg     <= '0;
            fetch_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.init_xor)
                xor_reg <= hdr_first_reg;
            else if (cmd.add_hdr2)
                xor_reg <= xor_reg ^ hdr_second_reg;
            else if (store_en)
                xor_reg <= xor_reg ^ rx_byte;

            if (cmd.add_hdr2)
                windex_reg <= '0;
            else if (store_en)
                windex_reg <= windex_reg + CNT_W'(1);

            if (cmd.start_len)
            begin
                left_reg <= rx_byte[LEN_W-1:0];
                len_reg  <= rx_byte[LEN_W-1:0];
            end
            else if (cmd.store_payload)
            begin
                left_reg <= left_reg - LEN_W'(1);
            end

            // One read per byte: advance address, then wait for fresh data.
            if (cmd.start_drain)
            begin
                rd_addr_reg     <= '0;
                fetch_valid_reg <= 1'b0;
            end
            else if (cmd.emit)
            begin
                rd_addr_reg     <= rd_addr_reg + IDX_W'(1);
                fetch_valid_reg <= 1'b0;
            end
            else
            begin
                fetch_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
            store_mem[windex_reg[IDX_W-1:0]] <= rx_byte;
        rd_data_reg <= store_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= stat.drain_last;
        end
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_comb
    begin
        stat.hdr1_match  = (rx_byte == hdr_first_reg);
        stat.hdr2_match  = (rx_byte == hdr_second_reg);
        stat.len_ok      = (rx_byte != '0) && (rx_byte <= BYTE_W'(MAX_LEN));
        stat.left_zero   = (left_reg == '0);
        stat.sum_match   = (rx_byte == xor_reg);
        stat.out_load_ok = fetch_valid_reg && (!out_valid_reg || m_tready);
        stat.drain_last  = (LEN_W'(rd_addr_reg) == len_reg);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule : sfr_dp

`default_nettype wire

@@ rtl/serial_frame_receiver_unit.sv @@
// Top level of the serial frame receiver: joins the controller and datapath.
// Depends on sfr_pkg, sfr_ctrl and sfr_dp.
//
// Usage:
//   The slave stream carries received UART bytes, one per transfer: s_tdata
//   holds the byte, s_tuser flags a receive error. Error bytes are taken and
//   dropped. The block hunts for two header bytes, a length byte (1..31),
//   that many payload bytes and an XOR checksum byte. On a good checksum the
//   master stream replays the length byte and the payload, m_tlast on the
//   final byte; a bad, zero or oversized length and a bad checksum drop the
//   frame silently.
//   Throughput: while receiving, one byte per cycle. After a good checksum
//   the block holds s_tready low for the burst of length+1 stored bytes;
//   each one is fetched by a registered read of the frame memory and then
//   loaded into the output register before the next one is fetched. After
//   the checksum transfer the read address is reset to the length byte.
//   A stalled master side holds the burst in place (the output register
//   keeps its byte); once the burst is read out, input resumes even if the
//   final byte still waits on m_tready.
//   Reset: hunting the first header, headers back to 0x55 and 0xCC, no
//   output pending. The frame memory needs no clearing pass.
//   Configuration: cfg_we with cfg_index 0 (first header) or 1 (second
//   header); write only while the block is idle.
`default_nettype none

module serial_frame_receiver_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sfr_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sfr_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  wire logic                          s_tuser,   // [0] rx_error
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] frame_byte
    output logic                               m_tlast
);
    import sfr_pkg::*;

    sfr_cmd_t  cmd;
    sfr_stat_t stat;

    // Controller: decides what each transferred byte means.
    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: checksum, frame memory and output register.
    sfr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // A good checksum must close the input side for the burst.
    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_drain |=> !s_tready)
        else $error("input still open after checksum accept");

    // Loading the final stored byte presents it marked last.
    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.drain_last) |=> (m_tvalid && m_tlast))
        else $error("final burst byte not marked last");

    // Never store past the announced payload length.
    a_no_overstore: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_payload |-> !stat.left_zero)
        else $error("payload stored beyond length");

    // No byte is emitted while the input side is taking data.
    a_emit_only_closed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !s_tready)
        else $error("emit while input open");
`endif

endmodule : serial_frame_receiver_unit

`default_nettype wire
